// ===== sv/csmm_pkg.sv =====
// ----------------------------------------------------------------------------
// csmm_pkg
// Shared types and constants for the complex square matrix multiplier.
// ----------------------------------------------------------------------------
package csmm_pkg;

  localparam int MAX_SIZE_DEF   = 8;
  localparam int PART_WIDTH_DEF = 16;

  // full-precision result part
  localparam int OUT_WIDTH   = 36;
  localparam int OUT_TDATA_W = ((2 * OUT_WIDTH + 7) / 8) * 8;

  localparam int CFG_WIDTH = 4;
  localparam logic [CFG_WIDTH-1:0] SIZE_RESET = 4'd8;

  // control bits that travel with an a element along the cell chain
  typedef struct packed {
    logic valid;
    logic first;
  } tok_ctrl_t;

endpackage

// ===== sv/csmm_cell.sv =====
// ----------------------------------------------------------------------------
// csmm_cell
// One multiply-accumulate cell: holds column CELL_IDX of B, multiplies the
// passing a element by B[k][CELL_IDX] and accumulates one element of C.
// ----------------------------------------------------------------------------
module csmm_cell #(
  parameter int PART_WIDTH = csmm_pkg::PART_WIDTH_DEF,
  parameter int MAX_SIZE   = csmm_pkg::MAX_SIZE_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // token from the left neighbor
  input  csmm_pkg::tok_ctrl_t                    tok_ctl_i,
  input  logic [$clog2(MAX_SIZE)-1:0]            tok_k_i,
  input  logic signed [PART_WIDTH-1:0]           tok_a_re_i,
  input  logic signed [PART_WIDTH-1:0]           tok_a_im_i,
  // token to the right neighbor
  output csmm_pkg::tok_ctrl_t                    tok_ctl_o,
  output logic [$clog2(MAX_SIZE)-1:0]            tok_k_o,
  output logic signed [PART_WIDTH-1:0]           tok_a_re_o,
  output logic signed [PART_WIDTH-1:0]           tok_a_im_o,
  // b element load
  input  logic                                   wr_en,
  input  logic [$clog2(MAX_SIZE)-1:0]            wr_row,
  input  logic [$clog2(MAX_SIZE)-1:0]            wr_col,
  input  logic signed [PART_WIDTH-1:0]           wr_re,
  input  logic signed [PART_WIDTH-1:0]           wr_im,
  // accumulated element
  output logic signed [csmm_pkg::OUT_WIDTH-1:0]  acc_re,
  output logic signed [csmm_pkg::OUT_WIDTH-1:0]  acc_im
);

  localparam int IDX_W  = $clog2(MAX_SIZE);
  localparam int PROD_W = 2 * PART_WIDTH;
  localparam int OUT_W  = csmm_pkg::OUT_WIDTH;
  localparam int SUM_W  = (PROD_W + 2 > OUT_W) ? PROD_W + 2 : OUT_W;

  logic [2*PART_WIDTH-1:0] b_mem [MAX_SIZE];

  // stage 1: b read, token held (also the hand-off to the neighbor)
  csmm_pkg::tok_ctrl_t         ctl1_r;
  logic [IDX_W-1:0]            k1_r;
  logic signed [PART_WIDTH-1:0] a_re_r, a_im_r, b_re_r, b_im_r;
  // stage 2: products
  csmm_pkg::tok_ctrl_t         ctl2_r;
  logic signed [PROD_W-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [PROD_W-1:0]    p_rr_nxt, p_ii_nxt, p_ri_nxt, p_ir_nxt;
  // stage 3: accumulate
  logic signed [OUT_W-1:0]     acc_re_r, acc_im_r, acc_re_nxt, acc_im_nxt;
  logic signed [SUM_W-1:0]     term_re, term_im;

  always_ff @(posedge clk) begin
    if (wr_en && wr_col == IDX_W'(CELL_IDX)) begin
      b_mem[wr_row] <= {wr_im, wr_re};
    end
    {b_im_r, b_re_r} <= b_mem[tok_k_i];
  end

  always_comb begin
    p_rr_nxt = a_re_r * b_re_r;
    p_ii_nxt = a_im_r * b_im_r;
    p_ri_nxt = a_re_r * b_im_r;
    p_ir_nxt = a_im_r * b_re_r;
  end

  always_comb begin
    term_re    = SUM_W'(p_rr_r) - SUM_W'(p_ii_r);
    term_im    = SUM_W'(p_ri_r) + SUM_W'(p_ir_r);
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (ctl2_r.valid) begin
      acc_re_nxt = (ctl2_r.first ? '0 : acc_re_r) + term_re[OUT_W-1:0];
      acc_im_nxt = (ctl2_r.first ? '0 : acc_im_r) + term_im[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= tok_ctl_i;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    k1_r     <= tok_k_i;
    a_re_r   <= tok_a_re_i;
    a_im_r   <= tok_a_im_i;
    p_rr_r   <= p_rr_nxt;
    p_ii_r   <= p_ii_nxt;
    p_ri_r   <= p_ri_nxt;
    p_ir_r   <= p_ir_nxt;
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
  end

  assign tok_ctl_o  = ctl1_r;
  assign tok_k_o    = k1_r;
  assign tok_a_re_o = a_re_r;
  assign tok_a_im_o = a_im_r;
  assign acc_re     = acc_re_r;
  assign acc_im     = acc_im_r;

endmodule

// ===== sv/complex_square_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// complex_square_matrix_multiply
// Streams in A and B element pairs, computes C = A * B, streams out C.
// ----------------------------------------------------------------------------
// Load n*n words (one element of A and the same element of B each, row-major)
// at one word per cycle, n = matrix_size clamped to 1..MAX_SIZE. The product
// is then formed one row of C at a time by a chain of MAX_SIZE complex
// multiply-accumulate cells, cell j holding column j of B: the n elements of
// row i of A are read from the A memory one per cycle and walk down the chain.
// Each row goes through an issue phase, a drain phase while the chain empties
// and an output phase that stalls while out_tready is held low. The input is
// not ready while the product is computed and sent; the last result word may
// still wait in the output register while the next matrix loads. Results are
// exact 36-bit sums, C row-major, out_tlast on the final element. Writing
// matrix_size restarts loading.
// ----------------------------------------------------------------------------
module complex_square_matrix_multiply #(
  parameter int MAX_SIZE   = csmm_pkg::MAX_SIZE_DEF,
  parameter int PART_WIDTH = csmm_pkg::PART_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // a_real, a_imag, b_real, b_imag (lowest bits first)
  input  logic [((4*PART_WIDTH+7)/8)*8-1:0]      in_tdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // c_real, c_imag (lowest bits first)
  output logic [csmm_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_wen,
  input  logic [csmm_pkg::CFG_WIDTH-1:0]         cfg_wdata
);

  localparam int IDX_W     = $clog2(MAX_SIZE);
  localparam int N_W       = $clog2(MAX_SIZE + 1);
  localparam int A_DEPTH   = 1 << (2 * IDX_W);
  localparam int OUT_W     = csmm_pkg::OUT_WIDTH;
  localparam int DRAIN_CYC = MAX_SIZE + 3;
  localparam int DR_W      = $clog2(DRAIN_CYC + 1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_COMP = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [csmm_pkg::CFG_WIDTH-1:0] size_r;
  logic [N_W-1:0]                 n_dim;
  logic [IDX_W-1:0]               n_m1;
  logic [IDX_W-1:0]               row_r, row_nxt, col_r, col_nxt;
  logic [IDX_W-1:0]               i_r, i_nxt, kj_r, kj_nxt;
  logic [DR_W-1:0]                drain_r, drain_nxt;
  logic                           in_acc, out_load;

  logic signed [PART_WIDTH-1:0]   in_a_re, in_a_im, in_b_re, in_b_im;

  logic [2*PART_WIDTH-1:0]        a_mem [A_DEPTH];
  logic [2*PART_WIDTH-1:0]        a_rd_r;
  csmm_pkg::tok_ctrl_t            issue_ctl_r, issue_ctl_nxt;
  logic [IDX_W-1:0]               issue_k_r;

  // chain taps: index j feeds cell j, index MAX_SIZE is the chain end
  csmm_pkg::tok_ctrl_t            tok_ctl  [MAX_SIZE+1];
  logic [IDX_W-1:0]               tok_k    [MAX_SIZE+1];
  logic signed [PART_WIDTH-1:0]   tok_a_re [MAX_SIZE+1];
  logic signed [PART_WIDTH-1:0]   tok_a_im [MAX_SIZE+1];
  logic signed [OUT_W-1:0]        acc_re   [MAX_SIZE];
  logic signed [OUT_W-1:0]        acc_im   [MAX_SIZE];

  logic                           out_tvalid_r, out_tvalid_nxt;
  logic                           out_tlast_r, out_tlast_nxt;
  logic signed [OUT_W-1:0]        out_re_r, out_re_nxt, out_im_r, out_im_nxt;

  assign in_a_re = in_tdata[PART_WIDTH-1:0];
  assign in_a_im = in_tdata[2*PART_WIDTH-1:PART_WIDTH];
  assign in_b_re = in_tdata[3*PART_WIDTH-1:2*PART_WIDTH];
  assign in_b_im = in_tdata[4*PART_WIDTH-1:3*PART_WIDTH];

  // size 0 counts as 1, anything above MAX_SIZE as MAX_SIZE
  always_comb begin
    if (size_r == '0) begin
      n_dim = N_W'(1);
    end else if (32'(size_r) > MAX_SIZE) begin
      n_dim = N_W'(MAX_SIZE);
    end else begin
      n_dim = N_W'(size_r);
    end
    n_m1 = IDX_W'(n_dim - N_W'(1));
  end

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    i_nxt          = i_r;
    kj_nxt         = kj_r;
    drain_nxt      = drain_r;
    issue_ctl_nxt  = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tlast_nxt  = out_tlast_r;
    out_re_nxt     = out_re_r;
    out_im_nxt     = out_im_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (col_r == n_m1) begin
            col_nxt = '0;
            if (row_r == n_m1) begin
              row_nxt   = '0;
              i_nxt     = '0;
              kj_nxt    = '0;
              state_nxt = ST_COMP;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      ST_COMP: begin
        issue_ctl_nxt.valid = 1'b1;
        issue_ctl_nxt.first = (kj_r == '0);
        if (kj_r == n_m1) begin
          kj_nxt    = '0;
          drain_nxt = '0;
          state_nxt = ST_WAIT;
        end else begin
          kj_nxt = kj_r + 1'b1;
        end
      end
      ST_WAIT: begin
        if (drain_r == DR_W'(DRAIN_CYC - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          drain_nxt = drain_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_re_nxt     = acc_re[kj_r];
          out_im_nxt     = acc_im[kj_r];
          out_tlast_nxt  = (i_r == n_m1) && (kj_r == n_m1);
          if (kj_r == n_m1) begin
            kj_nxt = '0;
            if (i_r == n_m1) begin
              state_nxt = ST_LOAD;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = ST_COMP;
            end
          end else begin
            kj_nxt = kj_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
    // a size write restarts loading
    if (cfg_wen) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      size_r       <= csmm_pkg::SIZE_RESET;
      row_r        <= '0;
      col_r        <= '0;
      i_r          <= '0;
      kj_r         <= '0;
      drain_r      <= '0;
      issue_ctl_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      i_r          <= i_nxt;
      kj_r         <= kj_nxt;
      drain_r      <= drain_nxt;
      issue_ctl_r  <= issue_ctl_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wen) begin
        size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_mem[{row_r, col_r}] <= {in_a_im, in_a_re};
    end
    a_rd_r      <= a_mem[{i_r, kj_r}];
    issue_k_r   <= kj_r;
    out_tlast_r <= out_tlast_nxt;
    out_re_r    <= out_re_nxt;
    out_im_r    <= out_im_nxt;
  end

  assign tok_ctl[0]  = issue_ctl_r;
  assign tok_k[0]    = issue_k_r;
  assign tok_a_re[0] = a_rd_r[PART_WIDTH-1:0];
  assign tok_a_im[0] = a_rd_r[2*PART_WIDTH-1:PART_WIDTH];

  for (genvar j = 0; j < MAX_SIZE; j++) begin : g_cell
    csmm_cell #(
      .PART_WIDTH (PART_WIDTH),
      .MAX_SIZE   (MAX_SIZE),
      .CELL_IDX   (j)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_ctl_i  (tok_ctl[j]),
      .tok_k_i    (tok_k[j]),
      .tok_a_re_i (tok_a_re[j]),
      .tok_a_im_i (tok_a_im[j]),
      .tok_ctl_o  (tok_ctl[j+1]),
      .tok_k_o    (tok_k[j+1]),
      .tok_a_re_o (tok_a_re[j+1]),
      .tok_a_im_o (tok_a_im[j+1]),
      .wr_en      (in_acc),
      .wr_row     (row_r),
      .wr_col     (col_r),
      .wr_re      (in_b_re),
      .wr_im      (in_b_im),
      .acc_re     (acc_re[j]),
      .acc_im     (acc_im[j])
    );
  end

  assign out_tdata  = {{(csmm_pkg::OUT_TDATA_W - 2*OUT_W){1'b0}}, out_im_r, out_re_r};
  assign out_tlast  = out_tlast_r;
  assign out_tvalid = out_tvalid_r;

  // a word enters the chain only right after an issue cycle
  a_issue_from_comp: assert property (@(posedge clk) disable iff (!rst_n)
    issue_ctl_r.valid |-> $past(state_r) == ST_COMP)
    else $error("chain token without issue cycle");

  // a new result word is only loaded from the output state
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !$past(out_tvalid_r)) |-> $past(state_r) == ST_OUT)
    else $error("result word outside output phase");

  // once draining starts, nothing more is issued into the chain
  a_no_issue_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && $past(state_r) == ST_WAIT) |-> !issue_ctl_r.valid)
    else $error("issue during drain");

endmodule

// ===== verif/complex_square_matrix_multiply_tb.sv =====
// ----------------------------------------------------------------------------
// complex_square_matrix_multiply_tb
// Loads A/B element pairs at several matrix sizes and checks every C element.
// ----------------------------------------------------------------------------
// A short table walks known products at sizes 0 and 1, a partial
// load dropped by a size write, and small 2x2 products. Random matrix loads
// follow, one full 8x8 pass and many small ones, with some loads cut short.
// Each C word is checked against a local integer model of C = A * B while
// the sender pauses in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module complex_square_matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_N       = csmm_pkg::MAX_SIZE_DEF;
  localparam int PART_W      = csmm_pkg::PART_WIDTH_DEF;
  localparam int OUT_W       = csmm_pkg::OUT_WIDTH;
  localparam int OUT_TDATA_W = csmm_pkg::OUT_TDATA_W;
  localparam int CFG_W       = csmm_pkg::CFG_WIDTH;
  localparam int IN_TDATA_W  = ((4 * PART_W + 7) / 8) * 8;
  localparam int SETTLE      = 20;   // idle cycles before a size write
  localparam int DRAIN       = 60;   // quiet cycles at the end
  localparam int RAND_PAIRS  = 80;

  typedef logic signed [PART_W-1:0] part_t;
  typedef logic signed [OUT_W-1:0]  sum_t;

  typedef struct packed {
    sum_t re;
    sum_t im;
    logic last;
  } c_elem_t;

  typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_t;
  typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [CFG_W-1:0] size;
    part_t          ar;
    part_t          ai;
    part_t          br;
    part_t          bi;
    logic           typed;
    sum_t           c_re;
    sum_t           c_im;
  } plan_row_t;

  logic                     clk;
  logic                     rst_n;
  logic [IN_TDATA_W-1:0]    in_tdata;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [OUT_TDATA_W-1:0]   out_tdata;
  logic                     out_tlast;
  logic                     out_tvalid;
  logic                     out_tready;
  logic                     cfg_wen;
  logic [CFG_W-1:0]         cfg_wdata;

  // local copy of the block's state
  part_t                a_re_store [MAX_N*MAX_N];
  part_t                a_im_store [MAX_N*MAX_N];
  part_t                b_re_store [MAX_N*MAX_N];
  part_t                b_im_store [MAX_N*MAX_N];
  int unsigned          pairs_held;
  logic [CFG_W-1:0]     size_reg;

  c_elem_t     pending_c[$];
  int unsigned errors;
  int unsigned pairs_loaded;
  int unsigned c_checked;
  int unsigned size_writes;
  int unsigned burst_left;
  ready_mode_t ready_mode;
  int unsigned mode_left;

  // kind, size, a_re, a_im, b_re, b_im, typed, c_re, c_im
  plan_row_t directed_plan [0:25] = '{
    // partial load at the reset size, dropped by the write below
    '{ROW_WORD, 4'd0, 16'sd1234, -16'sd77, -16'sd4000, 16'sd9, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b0, 36'sd0, 36'sd0},
    '{ROW_SIZE, 4'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
      1'b1, 36'sd0, 36'sd2147483648},
    '{ROW_WORD, 4'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
      1'b1, 36'sd0, 36'sd2147352578},
    '{ROW_WORD, 4'd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
      1'b1, 36'sd0, 36'sd2147418113},
    '{ROW_WORD, 4'd0, -16'sd1, 16'sd0, 16'sd0, -16'sd1, 1'b1, 36'sd0, 36'sd1},
    '{ROW_WORD, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 36'sd0, 36'sd0},
    // size 0 runs as 1
    '{ROW_SIZE, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b1, -36'sd5, 36'sd10},
    '{ROW_SIZE, 4'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sd256, -16'sd3, 16'sd100, -16'sd200, 1'b0, 36'sd0, 36'sd0},
    // a 3x3 load cut short by the next size write
    '{ROW_SIZE, 4'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sd7, 16'sd8, 16'sd9, 16'sd10, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sd0, 16'sh8000, 16'sd0, 16'sh7fff, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, -16'sd9, 16'sd3, 16'sd3, -16'sd9, 1'b0, 36'sd0, 36'sd0},
    '{ROW_SIZE, 4'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sd2, -16'sd2, 16'sd3, 16'sd3, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sh8000, 16'sd1, 16'sh7fff, -16'sd1, 1'b0, 36'sd0, 36'sd0},
    '{ROW_WORD, 4'd0, 16'sd4, 16'sd5, -16'sd6, 16'sd7, 1'b0, 36'sd0, 36'sd0}
  };

  complex_square_matrix_multiply u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // store one A/B pair; the n*n-th pair yields every element of C
  function automatic void load_element_pair(part_t ar, part_t ai, part_t br, part_t bi);
    int unsigned n;
    int unsigned total;
    sum_t        re;
    sum_t        im;
    n = (size_reg == 0) ? 1 : (size_reg > MAX_N) ? MAX_N : size_reg;
    total = n * n;
    if (pairs_held >= total) pairs_held = 0;
    a_re_store[pairs_held] = ar;
    a_im_store[pairs_held] = ai;
    b_re_store[pairs_held] = br;
    b_im_store[pairs_held] = bi;
    pairs_held++;
    if (pairs_held < total) return;
    pairs_held = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        re = '0;
        im = '0;
        for (int k = 0; k < n; k++) begin
          re = re + sum_t'(a_re_store[i*n+k]) * sum_t'(b_re_store[k*n+j])
                  - sum_t'(a_im_store[i*n+k]) * sum_t'(b_im_store[k*n+j]);
          im = im + sum_t'(a_re_store[i*n+k]) * sum_t'(b_im_store[k*n+j])
                  + sum_t'(a_im_store[i*n+k]) * sum_t'(b_re_store[k*n+j]);
        end
        pending_c.push_back('{re: re, im: im, last: (i == n-1 && j == n-1)});
      end
    end
  endfunction

  function automatic part_t pick_part();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return part_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_word(input part_t ar, input part_t ai, input part_t br,
                           input part_t bi);
    in_tdata  <= {bi, br, ai, ar};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    load_element_pair(ar, ai, br, bi);
    pairs_loaded++;
  endtask

  // keep tvalid up inside a burst, else drop it and maybe pause
  task automatic pace_sender(input bit more);
    if (more && burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      if (more) repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_results_out();
    while (pending_c.size() != 0) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] value);
    wait_results_out();
    repeat (SETTLE) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    size_reg   = value;
    pairs_held = 0;
    size_writes++;
  endtask

  // receiver readiness switches between a few stall styles
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(8, 80);
    end
    mode_left--;
    case (ready_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_HALF:   out_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:    out_tready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    c_elem_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_c.size() == 0) begin
        $display("%0t: unexpected word c_real=%0d c_imag=%0d last=%0b", $time,
                 sum_t'(out_tdata[OUT_W-1:0]),
                 sum_t'(out_tdata[2*OUT_W-1:OUT_W]), out_tlast);
        errors++;
      end else begin
        want = pending_c.pop_front();
        c_checked++;
        if (out_tdata[OUT_W-1:0] !== want.re) begin
          $display("%0t: c_real expected %0d actual %0d", $time, want.re,
                   sum_t'(out_tdata[OUT_W-1:0]));
          errors++;
        end
        if (out_tdata[2*OUT_W-1:OUT_W] !== want.im) begin
          $display("%0t: c_imag expected %0d actual %0d", $time, want.im,
                   sum_t'(out_tdata[2*OUT_W-1:OUT_W]));
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned rand_pairs;
    int unsigned n;
    int unsigned count;
    logic [CFG_W-1:0] sz;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tdata   = '0;
    in_tvalid  = 1'b0;
    out_tready = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = '0;
    size_reg   = csmm_pkg::SIZE_RESET;
    pairs_held = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < $size(directed_plan); r++) begin
      if (directed_plan[r].kind == ROW_SIZE) begin
        set_size(directed_plan[r].size);
      end else begin
        send_word(directed_plan[r].ar, directed_plan[r].ai,
                  directed_plan[r].br, directed_plan[r].bi);
        if (directed_plan[r].typed) begin
          void'(pending_c.pop_back());
          pending_c.push_back('{re: directed_plan[r].c_re, im: directed_plan[r].c_im,
                                 last: 1'b1});
        end
        pace_sender(r + 1 < $size(directed_plan) &&
                    directed_plan[r+1].kind == ROW_WORD);
      end
    end

    // one full pass at the largest size, written as 15 so it clamps to 8
    rand_pairs = 0;
    set_size(4'd15);
    for (int p = 0; p < MAX_N * MAX_N; p++) begin
      send_word(pick_part(), pick_part(), pick_part(), pick_part());
      pace_sender(p + 1 < MAX_N * MAX_N);
      rand_pairs++;
    end

    // small matrices, now and then a load cut short by the next size write
    while (rand_pairs < RAND_PAIRS) begin
      sz = CFG_W'($urandom_range(0, 4));
      n  = (sz == 0) ? 1 : sz;
      set_size(sz);
      if (n > 1 && $urandom_range(0, 4) == 0) count = $urandom_range(1, n * n - 1);
      else count = n * n * $urandom_range(1, 3);
      for (int p = 0; p < count; p++) begin
        send_word(pick_part(), pick_part(), pick_part(), pick_part());
        pace_sender(p + 1 < count);
        rand_pairs++;
      end
    end

    wait_results_out();
    repeat (DRAIN) @(posedge clk);
    $display("loaded %0d element pairs under %0d size writes, sizes 1 to 8",
             pairs_loaded, size_writes);
    $display("checked %0d product elements, %0d errors", c_checked, errors);
    if (errors == 0) begin
      $display("complex_square_matrix_multiply: match");
    end else begin
      $display("complex_square_matrix_multiply: mismatch");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("timeout with %0d product elements outstanding", pending_c.size());
    $display("complex_square_matrix_multiply: mismatch");
    $finish;
  end

endmodule
